@@ rtl/nfa_sm_pkg.sv @@
// ----------------------------------------------------------------------------
// NFA string matcher package
// Shared constants and the operation code type of the NFA string matcher.
// ----------------------------------------------------------------------------
package nfa_sm_pkg;

	// Default automaton size and transition slots per state.
	localparam int MAX_STATES_DEF = 16;
	localparam int MAX_EDGES_DEF  = 4;

	// Field widths of an input item.
	localparam int OP_W     = 2;
	localparam int STATE_W  = 4;
	localparam int SLOT_W   = 2;
	localparam int SYMBOL_W = 8;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int COUNT_W    = 5;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	// Register index, taken from the word part of the byte address.
	localparam logic REG_STATE_COUNT = 1'b0;

	// Operation codes of an input item.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_SYMBOL = 2'd2
	} op_t;

endpackage

@@ rtl/nfa_string_matcher.sv @@
// ----------------------------------------------------------------------------
// NFA string matcher
// Runs a nondeterministic finite automaton over a byte string, holding the set
// of active states and comparing every transition slot against each symbol.
// ----------------------------------------------------------------------------
// Items pass the input register, then the result register. One item per
// cycle is taken while out_ready holds; while a result waits, only an empty
// input register takes one. The whole transition table is compared with the
// symbol at once. Reset clears all transition slots to invalid, makes state 0
// the only active state, sets the string alive and loads a state count of 16.
module nfa_string_matcher
	import nfa_sm_pkg::*;
#(
	parameter int MAX_STATES = MAX_STATES_DEF,
	parameter int MAX_EDGES  = MAX_EDGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB-style configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// Input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [STATE_W-1:0]    edge_state,
	input  logic [SLOT_W-1:0]     edge_slot,
	input  logic [SYMBOL_W-1:0]   edge_symbol,
	input  logic [STATE_W-1:0]    edge_target,
	input  logic                  edge_valid,
	input  logic [SYMBOL_W-1:0]   symbol,
	input  logic                  last_symbol,
	// Output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  alive,
	output logic                  accepted,
	output logic                  string_done
);

	localparam int CNT_W = $clog2(MAX_STATES + 1);

	// Configuration register.
	logic [COUNT_W-1:0] state_count_q;
	logic               cfg_write;
	logic [CNT_W-1:0]   eff_count;

	// Input register.
	logic                valid_s1;
	op_t                 op_s1;
	logic [STATE_W-1:0]  edge_state_s1;
	logic [SLOT_W-1:0]   edge_slot_s1;
	logic [SYMBOL_W-1:0] edge_symbol_s1;
	logic [STATE_W-1:0]  edge_target_s1;
	logic                edge_valid_s1;
	logic [SYMBOL_W-1:0] symbol_s1;
	logic                last_s1;

	// Automaton state.
	logic [SYMBOL_W-1:0] slot_sym_q [MAX_STATES][MAX_EDGES];
	logic [STATE_W-1:0]  slot_tgt_q [MAX_STATES][MAX_EDGES];
	logic                slot_vld_q [MAX_STATES][MAX_EDGES];
	logic [MAX_STATES-1:0] active_q;
	logic                  alive_q;

	// Result register.
	logic out_valid_s2;
	logic alive_s2;
	logic accepted_s2;
	logic done_s2;

	// Next-item logic.
	logic                  advance;
	logic [MAX_STATES-1:0] next_set;
	logic [MAX_STATES-1:0] active_d;
	logic                  alive_d;
	logic                  accepted_d;
	logic                  done_d;
	logic                  final_hit;

	// Configuration writes and reads; the port never stalls.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= COUNT_RESET;
		end else if (cfg_write && paddr[2] == REG_STATE_COUNT) begin
			state_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_STATE_COUNT) begin
			prdata = APB_DATA_W'(state_count_q);
		end else begin
			prdata = '0;
		end
	end

	// A count of zero acts as one, and a count above the table size is clipped.
	always_comb begin
		if (state_count_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (int'(state_count_q) > MAX_STATES) begin
			eff_count = CNT_W'(MAX_STATES);
		end else begin
			eff_count = CNT_W'(state_count_q);
		end
	end

	// Handshake: the input register moves on whenever the result register is free.
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Item payload is captured without reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1          <= op_t'(operation);
			edge_state_s1  <= edge_state;
			edge_slot_s1   <= edge_slot;
			edge_symbol_s1 <= edge_symbol;
			edge_target_s1 <= edge_target;
			edge_valid_s1  <= edge_valid;
			symbol_s1      <= symbol;
			last_s1        <= last_symbol;
		end
	end

	// Every slot of every state in use is compared with the symbol in parallel,
	// and each firing slot sets its target in the next active set.
	always_comb begin
		next_set = '0;
		for (int s = 0; s < MAX_STATES; s++) begin
			for (int k = 0; k < MAX_EDGES; k++) begin
				for (int t = 0; t < MAX_STATES; t++) begin
					if (s < int'(eff_count) && active_q[s] && slot_vld_q[s][k]
						&& slot_sym_q[s][k] == symbol_s1
						&& int'(slot_tgt_q[s][k]) < int'(eff_count)
						&& int'(slot_tgt_q[s][k]) == t) begin
						next_set[t] = 1'b1;
					end
				end
			end
		end
	end

	// Next active set and string flags for the item in the input register.
	always_comb begin
		active_d = active_q;
		alive_d  = alive_q;
		done_d   = 1'b0;
		unique case (op_s1)
			OP_START: begin
				active_d = MAX_STATES'(1);
				alive_d  = 1'b1;
				done_d   = last_s1;
			end
			OP_SYMBOL: begin
				if (alive_q) begin
					active_d = next_set;
					alive_d  = |next_set;
				end
				done_d = last_s1;
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	// The accepting state is the last one in use.
	always_comb begin
		final_hit = 1'b0;
		for (int s = 0; s < MAX_STATES; s++) begin
			if (s == int'(eff_count) - 1) begin
				final_hit = active_d[s];
			end
		end
	end

	assign accepted_d = done_d && alive_d && final_hit;

	// Active set and alive flag follow each item as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= MAX_STATES'(1);
			alive_q  <= 1'b1;
		end else if (advance) begin
			active_q <= active_d;
			alive_q  <= alive_d;
		end
	end

	// Transition slot valid bits are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_STATES; s++) begin
				for (int k = 0; k < MAX_EDGES; k++) begin
					slot_vld_q[s][k] <= 1'b0;
				end
			end
		end else if (advance && op_s1 == OP_LOAD) begin
			for (int s = 0; s < MAX_STATES; s++) begin
				for (int k = 0; k < MAX_EDGES; k++) begin
					if (int'(edge_state_s1) == s && int'(edge_slot_s1) == k) begin
						slot_vld_q[s][k] <= edge_valid_s1;
					end
				end
			end
		end
	end

	// Slot symbol and target; a load beyond the table matches no slot.
	always_ff @(posedge clk) begin
		if (advance && op_s1 == OP_LOAD) begin
			for (int s = 0; s < MAX_STATES; s++) begin
				for (int k = 0; k < MAX_EDGES; k++) begin
					if (int'(edge_state_s1) == s && int'(edge_slot_s1) == k) begin
						slot_sym_q[s][k] <= edge_symbol_s1;
						slot_tgt_q[s][k] <= edge_target_s1;
					end
				end
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			alive_s2    <= alive_d;
			accepted_s2 <= accepted_d;
			done_s2     <= done_d;
		end
	end

	assign out_valid   = out_valid_s2;
	assign alive       = alive_s2;
	assign accepted    = accepted_s2;
	assign string_done = done_s2;

	// A dead string has no active states.
	assert property (@(posedge clk) disable iff (!arst_n)
		!alive_q |-> active_q == '0)
		else $error("dead string with active states");

	// Acceptance is only reported on a live string that has ended.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> alive && string_done)
		else $error("acceptance without a finished live string");

	// An item leaving the input register always shows up as a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("item lost between input and result registers");

endmodule
